### rtl/stp_topology_change_fsm_assert.svh
// assertion macros for the topology change machine
`ifndef STP_TOPOLOGY_CHANGE_FSM_ASSERT_SVH
`define STP_TOPOLOGY_CHANGE_FSM_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stp_tcm_pkg.sv
package stp_tcm_pkg;

    localparam int TimerWidth = 7;
    localparam int HelloWidth = 4;
    localparam int MaxAgeWidth = 6;
    localparam int FwdDelayWidth = 5;
    localparam int AddrWidth = 4;

    // port role codes
    localparam logic [1:0] ROLE_OTHER      = 2'd0;
    localparam logic [1:0] ROLE_ROOT       = 2'd1;
    localparam logic [1:0] ROLE_DESIGNATED = 2'd2;
    localparam logic [1:0] ROLE_MASTER     = 2'd3;

    // register indexes
    localparam logic [1:0] REG_COMMON_TREE = 2'd0;
    localparam logic [1:0] REG_HELLO_TIME  = 2'd1;
    localparam logic [1:0] REG_MAX_AGE     = 2'd2;
    localparam logic [1:0] REG_FWD_DELAY   = 2'd3;

    // register reset values
    localparam logic                     RST_COMMON_TREE = 1'b1;
    localparam logic [HelloWidth-1:0]    RST_HELLO_TIME  = 4'd2;
    localparam logic [MaxAgeWidth-1:0]   RST_MAX_AGE     = 6'd20;
    localparam logic [FwdDelayWidth-1:0] RST_FWD_DELAY   = 5'd15;

    typedef struct packed {
        logic [2:0]            fsm_state;
        logic [TimerWidth-1:0] change_timer;
        logic                  ack_pending;
        logic                  propagate_others;
        logic                  new_info;
    } result_t;

endpackage

### rtl/stp_topology_change_fsm.sv
// Topology change state machine for one spanning-tree port.
// Input channel (item_valid/item_stall) carries one evaluation step: port
// role, forwarding, edge, the set pulses for received tc, tcn, ack and
// propagate, the link flags and a one-second tick. Each accepted word
// yields exactly one result word on the output channel
// (result_valid/result_stall): state after the step, change timer, ack
// pending and the propagate_others and new_info pulses.
// The whole step is evaluated from the input ports and the state
// registers and lands in the output or skid register at the
// accepting edge. One word is accepted every cycle while the receiver
// takes results. When the receiver stalls, a one-word skid register
// catches the next result; item_stall rises only while that skid word
// is held, and drops once the output register drains.
// The APB port holds is_common_tree, hello_time, max_age and
// forward_delay at byte offsets 0, 4, 8 and 12; pready is always high.
// Reset puts the machine in init with the timer and all flags cleared,
// empties both result registers and loads the register defaults.
module stp_topology_change_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stp_tcm_pkg::AddrWidth-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          port_role,
    input  logic                                forwarding,
    input  logic                                edge_port,
    input  logic                                set_rcvd_tc,
    input  logic                                set_rcvd_tcn,
    input  logic                                set_rcvd_ack,
    input  logic                                set_propagate,
    input  logic                                sends_rstp,
    input  logic                                point_to_point,
    input  logic                                second_tick,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [2:0]                          fsm_state,
    output logic [stp_tcm_pkg::TimerWidth-1:0]  change_timer,
    output logic                                ack_pending,
    output logic                                propagate_others,
    output logic                                new_info
);

    typedef enum logic [2:0] {
        ST_INIT         = 3'd0,
        ST_INACTIVE     = 3'd1,
        ST_ACTIVE       = 3'd2,
        ST_DETECTED     = 3'd3,
        ST_NOTIFIED_TC  = 3'd4,
        ST_PROPAGATING  = 3'd5,
        ST_ACKNOWLEDGED = 3'd6,
        ST_NOTIFIED_TCN = 3'd7
    } state_t;

    // configuration registers
    logic                                     common_tree_reg;
    logic [stp_tcm_pkg::HelloWidth-1:0]       hello_time_reg;
    logic [stp_tcm_pkg::MaxAgeWidth-1:0]      max_age_reg;
    logic [stp_tcm_pkg::FwdDelayWidth-1:0]    fwd_delay_reg;
    logic                                     cfg_write;
    logic [1:0]                               cfg_index;

    // machine state
    state_t                                   state_reg, state_next;
    logic [stp_tcm_pkg::TimerWidth-1:0]       timer_reg, timer_next;
    logic                                     rcvd_tc_reg, rcvd_tc_next;
    logic                                     rcvd_tcn_reg, rcvd_tcn_next;
    logic                                     rcvd_ack_reg, rcvd_ack_next;
    logic                                     propagate_reg, propagate_next;
    logic                                     ack_reg, ack_next;

    // result output register and skid
    stp_tcm_pkg::result_t                     out_reg, out_next;
    stp_tcm_pkg::result_t                     skid_reg, skid_next;
    logic                                     out_valid_reg, out_valid_next;
    logic                                     skid_valid_reg, skid_valid_next;

    logic                                     accept;
    logic                                     out_taken;
    logic                                     active_role;
    logic [stp_tcm_pkg::TimerWidth-1:0]       timer_ticked;
    logic [stp_tcm_pkg::TimerWidth-1:0]       reload;
    logic                                     take_step;
    state_t                                   target;
    logic                                     prop_pulse;
    logic                                     info_pulse;
    stp_tcm_pkg::result_t                     result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_tree_reg <= stp_tcm_pkg::RST_COMMON_TREE;
            hello_time_reg  <= stp_tcm_pkg::RST_HELLO_TIME;
            max_age_reg     <= stp_tcm_pkg::RST_MAX_AGE;
            fwd_delay_reg   <= stp_tcm_pkg::RST_FWD_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stp_tcm_pkg::REG_COMMON_TREE: common_tree_reg <= pwdata[0];
                stp_tcm_pkg::REG_HELLO_TIME:
                    hello_time_reg <= pwdata[stp_tcm_pkg::HelloWidth-1:0];
                stp_tcm_pkg::REG_MAX_AGE:
                    max_age_reg <= pwdata[stp_tcm_pkg::MaxAgeWidth-1:0];
                stp_tcm_pkg::REG_FWD_DELAY:
                    fwd_delay_reg <= pwdata[stp_tcm_pkg::FwdDelayWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            stp_tcm_pkg::REG_COMMON_TREE: prdata = {31'd0, common_tree_reg};
            stp_tcm_pkg::REG_HELLO_TIME:
                prdata = {{(32-stp_tcm_pkg::HelloWidth){1'b0}}, hello_time_reg};
            stp_tcm_pkg::REG_MAX_AGE:
                prdata = {{(32-stp_tcm_pkg::MaxAgeWidth){1'b0}}, max_age_reg};
            stp_tcm_pkg::REG_FWD_DELAY:
                prdata = {{(32-stp_tcm_pkg::FwdDelayWidth){1'b0}}, fwd_delay_reg};
            default: prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign out_taken  = out_valid_reg && !result_stall;

    // ---------------- one evaluation step ----------------
    assign active_role  = (port_role != stp_tcm_pkg::ROLE_OTHER);
    assign timer_ticked = (second_tick && (timer_reg != '0)) ?
                          timer_reg - 1'b1 : timer_reg;
    // short reload sees the ticked timer
    assign reload = ((timer_ticked == '0) && sends_rstp && point_to_point) ?
                    stp_tcm_pkg::TimerWidth'({hello_time_reg, 1'b0}) :
                    stp_tcm_pkg::TimerWidth'(max_age_reg) +
                    stp_tcm_pkg::TimerWidth'(fwd_delay_reg);

    always_comb
    begin
        rcvd_tc_next   = rcvd_tc_reg | set_rcvd_tc;
        rcvd_tcn_next  = rcvd_tcn_reg | set_rcvd_tcn;
        rcvd_ack_next  = rcvd_ack_reg | set_rcvd_ack;
        propagate_next = propagate_reg | set_propagate;
        timer_next     = timer_ticked;
        ack_next       = ack_reg;
        state_next     = state_reg;
        prop_pulse     = 1'b0;
        info_pulse     = 1'b0;
        take_step      = 1'b1;
        target         = ST_ACTIVE;

        case (state_reg)
            ST_INIT: target = ST_INACTIVE;
            ST_INACTIVE:
            begin
                // any pending flag re-enters inactive; tcn and ack clear only on a common tree
                if (rcvd_tc_next || rcvd_tcn_next || rcvd_ack_next || propagate_next)
                    target = ST_INACTIVE;
                else if (active_role && forwarding && !edge_port)
                    target = ST_DETECTED;
                else
                    take_step = 1'b0;
            end
            ST_ACTIVE:
            begin
                if (!active_role)
                    target = ST_INIT;
                else if (rcvd_tcn_next)
                    target = ST_NOTIFIED_TCN;
                else if (rcvd_tc_next)
                    target = ST_NOTIFIED_TC;
                else if (propagate_next)
                    target = ST_PROPAGATING;
                else if (rcvd_ack_next)
                    target = ST_ACKNOWLEDGED;
                else
                    take_step = 1'b0;
            end
            ST_NOTIFIED_TCN: target = ST_NOTIFIED_TC;
            default: target = ST_ACTIVE;
        endcase

        if (take_step)
        begin
            state_next = target;
            case (target)
                ST_INIT:
                begin
                    timer_next = '0;
                    if (common_tree_reg)
                        ack_next = 1'b0;
                end
                ST_INACTIVE:
                begin
                    if (common_tree_reg)
                    begin
                        rcvd_tcn_next = 1'b0;
                        rcvd_ack_next = 1'b0;
                    end
                    rcvd_tc_next   = 1'b0;
                    propagate_next = 1'b0;
                end
                ST_DETECTED:
                begin
                    timer_next = reload;
                    prop_pulse = 1'b1;
                    info_pulse = 1'b1;
                end
                ST_NOTIFIED_TC:
                begin
                    if (common_tree_reg)
                        rcvd_tcn_next = 1'b0;
                    rcvd_tc_next = 1'b0;
                    if (common_tree_reg && (port_role == stp_tcm_pkg::ROLE_DESIGNATED))
                        ack_next = 1'b1;
                    prop_pulse = 1'b1;
                end
                ST_PROPAGATING:
                begin
                    timer_next     = reload;
                    propagate_next = 1'b0;
                end
                ST_ACKNOWLEDGED:
                begin
                    timer_next    = '0;
                    rcvd_ack_next = 1'b0;
                end
                ST_NOTIFIED_TCN: timer_next = reload;
                default: ;
            endcase
        end

        result.fsm_state        = state_next;
        result.change_timer     = timer_next;
        result.ack_pending      = ack_next;
        result.propagate_others = prop_pulse;
        result.new_info         = info_pulse;
    end

    // ---------------- result buffering ----------------
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_taken)
        begin
            out_valid_next = 1'b0;
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end

        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            timer_reg      <= '0;
            rcvd_tc_reg    <= 1'b0;
            rcvd_tcn_reg   <= 1'b0;
            rcvd_ack_reg   <= 1'b0;
            propagate_reg  <= 1'b0;
            ack_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                timer_reg     <= timer_next;
                rcvd_tc_reg   <= rcvd_tc_next;
                rcvd_tcn_reg  <= rcvd_tcn_next;
                rcvd_ack_reg  <= rcvd_ack_next;
                propagate_reg <= propagate_next;
                ack_reg       <= ack_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
        end
    end

    assign result_valid     = out_valid_reg;
    assign fsm_state        = out_reg.fsm_state;
    assign change_timer     = out_reg.change_timer;
    assign ack_pending      = out_reg.ack_pending;
    assign propagate_others = out_reg.propagate_others;
    assign new_info         = out_reg.new_info;

    // ---------------- checks ----------------
    `include "stp_topology_change_fsm_assert.svh"

    `STP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `STP_ASSERT_NEXT(a_info_in_detected, accept && info_pulse, state_reg == ST_DETECTED, "new_info without entering detected")
    `STP_ASSERT_NEXT(a_detected_leaves, accept && (state_reg == ST_DETECTED), state_reg == ST_ACTIVE, "detected did not move to active")
    `STP_ASSERT_NEXT(a_out_holds, out_valid_reg && result_stall, out_valid_reg && $stable(out_reg), "stalled result changed")

endmodule

### test/stp_topology_change_fsm_tb.sv
module stp_topology_change_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        TCM_INIT         = 3'd0,
        TCM_INACTIVE     = 3'd1,
        TCM_ACTIVE       = 3'd2,
        TCM_DETECTED     = 3'd3,
        TCM_NOTIFIED_TC  = 3'd4,
        TCM_PROPAGATING  = 3'd5,
        TCM_ACKNOWLEDGED = 3'd6,
        TCM_NOTIFIED_TCN = 3'd7
    } tcm_state_t;

    typedef struct packed {
        logic [1:0] port_role;
        logic       forwarding;
        logic       edge_port;
        logic       set_rcvd_tc;
        logic       set_rcvd_tcn;
        logic       set_rcvd_ack;
        logic       set_propagate;
        logic       sends_rstp;
        logic       point_to_point;
        logic       second_tick;
    } step_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [stp_tcm_pkg::AddrWidth-1:0]  paddr = '0;
    logic [31:0]                        pwdata = '0;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               item_valid = 1'b0;
    logic                               item_stall;
    logic [1:0]                         port_role = '0;
    logic                               forwarding = 1'b0;
    logic                               edge_port = 1'b0;
    logic                               set_rcvd_tc = 1'b0;
    logic                               set_rcvd_tcn = 1'b0;
    logic                               set_rcvd_ack = 1'b0;
    logic                               set_propagate = 1'b0;
    logic                               sends_rstp = 1'b0;
    logic                               point_to_point = 1'b0;
    logic                               second_tick = 1'b0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic [2:0]                         fsm_state;
    logic [stp_tcm_pkg::TimerWidth-1:0] change_timer;
    logic                               ack_pending;
    logic                               propagate_others;
    logic                               new_info;

    stp_topology_change_fsm u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .port_role        (port_role),
        .forwarding       (forwarding),
        .edge_port        (edge_port),
        .set_rcvd_tc      (set_rcvd_tc),
        .set_rcvd_tcn     (set_rcvd_tcn),
        .set_rcvd_ack     (set_rcvd_ack),
        .set_propagate    (set_propagate),
        .sends_rstp       (sends_rstp),
        .point_to_point   (point_to_point),
        .second_tick      (second_tick),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .fsm_state        (fsm_state),
        .change_timer     (change_timer),
        .ack_pending      (ack_pending),
        .propagate_others (propagate_others),
        .new_info         (new_info)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow configuration
    logic                                  cfg_common = stp_tcm_pkg::RST_COMMON_TREE;
    logic [stp_tcm_pkg::HelloWidth-1:0]    cfg_hello = stp_tcm_pkg::RST_HELLO_TIME;
    logic [stp_tcm_pkg::MaxAgeWidth-1:0]   cfg_max_age = stp_tcm_pkg::RST_MAX_AGE;
    logic [stp_tcm_pkg::FwdDelayWidth-1:0] cfg_fwd_delay = stp_tcm_pkg::RST_FWD_DELAY;

    // shadow machine state
    tcm_state_t                         tc_state = TCM_INIT;
    logic [stp_tcm_pkg::TimerWidth-1:0] tc_timer = '0;
    logic                               flag_tc = 1'b0;
    logic                               flag_tcn = 1'b0;
    logic                               flag_ack = 1'b0;
    logic                               flag_prop = 1'b0;
    logic                               ack_owed = 1'b0;

    step_t                 steps_pending[$];
    stp_tcm_pkg::result_t  results_due[$];
    int unsigned words_in = 0;
    int unsigned words_offered = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic [31:0] cyc = '0;
    int unsigned fail_count = 0;

    function automatic logic [stp_tcm_pkg::TimerWidth-1:0] reload_time(logic rstp, logic p2p);
        if (tc_timer == '0 && rstp && p2p)
            return {2'b00, cfg_hello, 1'b0};
        return {1'b0, cfg_max_age} + {2'b00, cfg_fwd_delay};
    endfunction

    function automatic stp_tcm_pkg::result_t tc_machine_step(step_t w);
        logic                 role_on;
        logic                 moved;
        tcm_state_t           nxt;
        stp_tcm_pkg::result_t r;
        role_on = (w.port_role != stp_tcm_pkg::ROLE_OTHER);
        moved = 1'b1;
        nxt = tc_state;
        r = '0;
        flag_tc   = flag_tc | w.set_rcvd_tc;
        flag_tcn  = flag_tcn | w.set_rcvd_tcn;
        flag_ack  = flag_ack | w.set_rcvd_ack;
        flag_prop = flag_prop | w.set_propagate;
        if (w.second_tick && tc_timer != '0)
            tc_timer = tc_timer - 1'b1;
        case (tc_state)
            TCM_INIT:
                nxt = TCM_INACTIVE;
            TCM_INACTIVE:
                if (flag_tc || flag_tcn || flag_ack || flag_prop)
                    nxt = TCM_INACTIVE;
                else if (role_on && w.forwarding && !w.edge_port)
                    nxt = TCM_DETECTED;
                else
                    moved = 1'b0;
            TCM_ACTIVE:
                if (!role_on)
                    nxt = TCM_INIT;
                else if (flag_tcn)
                    nxt = TCM_NOTIFIED_TCN;
                else if (flag_tc)
                    nxt = TCM_NOTIFIED_TC;
                else if (flag_prop)
                    nxt = TCM_PROPAGATING;
                else if (flag_ack)
                    nxt = TCM_ACKNOWLEDGED;
                else
                    moved = 1'b0;
            TCM_NOTIFIED_TCN:
                nxt = TCM_NOTIFIED_TC;
            default:
                nxt = TCM_ACTIVE;
        endcase
        if (moved)
        begin
            case (nxt)
                TCM_INIT:
                begin
                    tc_timer = '0;
                    if (cfg_common)
                        ack_owed = 1'b0;
                end
                TCM_INACTIVE:
                begin
                    if (cfg_common)
                    begin
                        flag_tcn = 1'b0;
                        flag_ack = 1'b0;
                    end
                    flag_tc = 1'b0;
                    flag_prop = 1'b0;
                end
                TCM_DETECTED:
                begin
                    tc_timer = reload_time(w.sends_rstp, w.point_to_point);
                    r.propagate_others = 1'b1;
                    r.new_info = 1'b1;
                end
                TCM_NOTIFIED_TC:
                begin
                    if (cfg_common)
                        flag_tcn = 1'b0;
                    flag_tc = 1'b0;
                    if (cfg_common && w.port_role == stp_tcm_pkg::ROLE_DESIGNATED)
                        ack_owed = 1'b1;
                    r.propagate_others = 1'b1;
                end
                TCM_PROPAGATING:
                begin
                    tc_timer = reload_time(w.sends_rstp, w.point_to_point);
                    flag_prop = 1'b0;
                end
                TCM_ACKNOWLEDGED:
                begin
                    tc_timer = '0;
                    flag_ack = 1'b0;
                end
                TCM_NOTIFIED_TCN:
                    tc_timer = reload_time(w.sends_rstp, w.point_to_point);
                default:
                    ;
            endcase
            tc_state = nxt;
        end
        r.fsm_state = tc_state;
        r.change_timer = tc_timer;
        r.ack_pending = ack_owed;
        return r;
    endfunction

    // mostly back to back, a few long gaps, and quiet windows with none
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cyc[9:8] == 2'b00)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic step_t rand_step(int unsigned dens);
        step_t s;
        if ($urandom_range(0, 99) < 85)
            s.port_role = 2'($urandom_range(1, 3));
        else
            s.port_role = 2'($urandom_range(0, 3));
        s.forwarding     = ($urandom_range(0, 99) < 85);
        s.edge_port      = ($urandom_range(0, 99) < 10);
        s.set_rcvd_tc    = ($urandom_range(0, 99) < dens);
        s.set_rcvd_tcn   = ($urandom_range(0, 99) < dens);
        s.set_rcvd_ack   = ($urandom_range(0, 99) < dens);
        s.set_propagate  = ($urandom_range(0, 99) < dens);
        s.sends_rstp     = 1'($urandom_range(0, 1));
        s.point_to_point = 1'($urandom_range(0, 1));
        s.second_tick    = ($urandom_range(0, 99) < 35);
        return s;
    endfunction

    function automatic step_t mk(logic [1:0] role, logic fwd, logic edg, logic tc, logic tcn,
                                 logic ack, logic prop, logic rstp, logic p2p, logic tick);
        return {role, fwd, edg, tc, tcn, ack, prop, rstp, p2p, tick};
    endfunction

    task automatic log_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // word driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || words_in == words_offered))
        begin
            if (send_gap != 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (steps_pending.size() != 0)
            begin
                {port_role, forwarding, edge_port, set_rcvd_tc, set_rcvd_tcn, set_rcvd_ack,
                 set_propagate, sends_rstp, point_to_point, second_tick}
                    <= steps_pending.pop_front();
                item_valid <= 1'b1;
                words_offered <= words_offered + 1;
                send_gap <= idle_len();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted input words, check accepted result words
    always @(posedge clk)
    begin : monitor
        stp_tcm_pkg::result_t due;
        stp_tcm_pkg::result_t got;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                results_due.push_back(tc_machine_step({port_role, forwarding, edge_port,
                    set_rcvd_tc, set_rcvd_tcn, set_rcvd_ack, set_propagate, sends_rstp,
                    point_to_point, second_tick}));
                words_in++;
            end
            if (result_valid && !result_stall)
            begin
                got = {fsm_state, change_timer, ack_pending, propagate_others, new_info};
                if (results_due.size() == 0)
                begin
                    log_failure($sformatf("unexpected result word %p", got));
                end
                else
                begin
                    due = results_due.pop_front();
                    if (got !== due)
                        log_failure($sformatf(
                            {"mismatch: state exp %0d got %0d, timer exp %0d got %0d, ",
                             "ack exp %0b got %0b, prop exp %0b got %0b, info exp %0b got %0b"},
                            due.fsm_state, got.fsm_state, due.change_timer, got.change_timer,
                            due.ack_pending, got.ack_pending, due.propagate_others,
                            got.propagate_others, due.new_info, got.new_info));
                end
            end
        end
    end

    // long receiver hold-off, once, so the skid fills and the input stalls
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_in >= 500)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left <= idle_len();
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val,
                             input int unsigned width);
        logic [31:0] noise;
        // junk above the register width should be dropped
        noise = ($urandom_range(0, 1) != 0) ? ($urandom() << width) : 32'd0;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val | noise;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            stp_tcm_pkg::REG_COMMON_TREE: cfg_common = val[0];
            stp_tcm_pkg::REG_HELLO_TIME:  cfg_hello = val[stp_tcm_pkg::HelloWidth-1:0];
            stp_tcm_pkg::REG_MAX_AGE:     cfg_max_age = val[stp_tcm_pkg::MaxAgeWidth-1:0];
            stp_tcm_pkg::REG_FWD_DELAY:   cfg_fwd_delay = val[stp_tcm_pkg::FwdDelayWidth-1:0];
            default:                      ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned ct, input int unsigned hello,
                                 input int unsigned age, input int unsigned fwd);
        reg_write(stp_tcm_pkg::REG_COMMON_TREE, ct, 1);
        reg_write(stp_tcm_pkg::REG_HELLO_TIME, hello, stp_tcm_pkg::HelloWidth);
        reg_write(stp_tcm_pkg::REG_MAX_AGE, age, stp_tcm_pkg::MaxAgeWidth);
        reg_write(stp_tcm_pkg::REG_FWD_DELAY, fwd, stp_tcm_pkg::FwdDelayWidth);
    endtask

    task automatic wait_drained();
        while (steps_pending.size() != 0 || item_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned dens);
        for (int unsigned i = 0; i < count; i++)
            steps_pending.push_back(rand_step(dens));
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk through every state under reset defaults
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_OTHER, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 1, 1, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 0, 0, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 0, 0, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 0, 0, 1));
        // tick brings the timer to zero in the same word that reloads it
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_ROOT, 1, 0, 0, 0, 0, 1, 1, 1, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_ROOT, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 1, 0, 0, 1, 1, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_DESIGNATED, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 0, 1, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_ROOT, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_ROOT, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_OTHER, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_OTHER, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_ROOT, 1, 0, 0, 1, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 0, 0, 0, 0, 0, 0, 1, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        steps_pending.push_back(mk(stp_tcm_pkg::ROLE_MASTER, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        run_random(200, 12);

        apply_setting(1, 1, 6, 4);
        run_random(200, 12);
        apply_setting(1, 10, 40, 30);
        run_random(200, 12);
        // non-common tree: stuck tcn or ack flags keep the port inactive
        apply_setting(0, 2, 20, 15);
        run_random(150, 4);
        // beyond the legal ranges
        apply_setting(1, 15, 63, 31);
        run_random(200, 12);
        apply_setting(0, 0, 0, 0);
        run_random(100, 4);
        apply_setting(1, 3, 20, 15);
        run_random(200, 15);
        repeat (4)
        begin
            apply_setting($urandom_range(0, 1), $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 31));
            run_random(100, 8 + $urandom_range(0, 8));
        end

        if (fail_count == 0)
            $display("stp_topology_change_fsm regression: pass");
        else
            $display("stp_topology_change_fsm regression: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("stp_topology_change_fsm regression: fail");
        $finish;
    end

endmodule

### stp_topology_change_fsm.f
+incdir+rtl
rtl/stp_tcm_pkg.sv
rtl/stp_topology_change_fsm.sv
test/stp_topology_change_fsm_tb.sv
